### rtl/integer_matrix_elementary_op_engine_macros.svh
// Assertion macros for the matrix operation engine.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef INTEGER_MATRIX_ELEMENTARY_OP_ENGINE_MACROS_SVH
`define INTEGER_MATRIX_ELEMENTARY_OP_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define IMEO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("imeo: same-cycle check failed");
`define IMEO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("imeo: next-cycle check failed");
`else
`define IMEO_ASSERT_IMP(lbl, ante, cons)
`define IMEO_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### rtl/imeo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package imeo_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;
  localparam int CNT_W = 5;

  typedef enum logic [3:0] {
    OP_WRITE      = 4'd0,
    OP_READ       = 4'd1,
    OP_SWAP_ROW   = 4'd2,
    OP_SWAP_COL   = 4'd3,
    OP_SCALE_ROW  = 4'd4,
    OP_SCALE_COL  = 4'd5,
    OP_ADD_ROW    = 4'd6,
    OP_ADD_COL    = 4'd7,
    OP_MIN_SEARCH = 4'd8,
    OP_ROW_CHECK  = 4'd9,
    OP_COL_CHECK  = 4'd10,
    OP_SUB_CHECK  = 4'd11,
    OP_COUNTS     = 4'd12
  } op_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ACC,
    S_LRA, S_LRB, S_LCAP, S_LMUL, S_LWA, S_LWB,
    S_PIV, S_PIVW, S_SRD, S_SEV, S_DIV,
    S_ZRD, S_ZEV, S_TRD, S_TEV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]         operation;
    logic [3:0]         first_index;
    logic [3:0]         second_index;
    logic signed [31:0] coeff;
    logic signed [31:0] write_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               found;
    logic [3:0]         found_row;
    logic [3:0]         found_col;
    logic [4:0]         zero_columns;
    logic [4:0]         torsion_count;
    logic               index_error;
  } out_beat_t;

  // Status of the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
    logic nz;
  } rem_sts_t;

  // Magnitude of a two's complement word; the most negative value maps to 2^31.
  function automatic logic [31:0] mag(input logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

endpackage
`default_nettype wire

### rtl/imeo_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module imeo_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [31:0]   wdata,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  // Single port, registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### rtl/imeo_rem.sv
`timescale 1ns / 1ps
`default_nettype none
module imeo_rem
  import imeo_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output rem_sts_t         sts
);

  localparam int W  = 32;
  localparam int CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          nz_r, nz_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // One restoring step per cycle: shift in a dividend bit, subtract if it fits.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    nz_nxt   = nz_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    shifted  = {rem_r[W-1:0], dvd_r[W-1]};
    trial    = (shifted >= {1'b0, dvs_r}) ? (shifted - {1'b0, dvs_r}) : shifted;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = trial;
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        nz_nxt   = (trial != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    nz_r  <= nz_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.nz   = nz_r;

endmodule
`default_nettype wire

### rtl/integer_matrix_elementary_op_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   in_data   (in_beat_t)
// out_     output     out_valid / out_stall out_data  (out_beat_t)
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// After reset a clearing pass writes zero to all MAX_ROWS*MAX_COLS words, one per cycle,
// and no beat is accepted until it ends. Row and column operations read, modify and
// write each element of the line through the single memory port.
// Searches and checks read each element scanned, and an element whose remainder by
// the pivot is needed goes through the bit-serial remainder unit.
// A finished result waits in the output register while a new beat is accepted.
module integer_matrix_elementary_op_engine
  import imeo_pkg::*;
#(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_beat_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_beat_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CNT_W-1:0]     cfg_data
);
  `include "integer_matrix_elementary_op_engine_macros.svh"

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_r, clr_nxt;
  logic [CNT_W-1:0]   row_cnt_r, col_cnt_r;
  op_t                op_r, op_nxt;
  logic [3:0]         a_r, a_nxt, b_r, b_nxt;
  logic [31:0]        k_r, k_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt, lim_r, lim_nxt, r_r, r_nxt, c_r, c_nxt;
  logic [31:0]        xa_r, xa_nxt, xb_r, xb_nxt, prod_r, prod_nxt;
  logic [31:0]        piv_r, piv_nxt, best_r, best_nxt, rv_r, rv_nxt;
  logic               fnd_r, fnd_nxt, err_r, err_nxt;
  logic [3:0]         fr_r, fr_nxt, fc_r, fc_nxt;
  logic [CNT_W-1:0]   zc_r, zc_nxt, tc_r, tc_nxt;
  logic               out_valid_r;
  out_beat_t          out_data_r;

  logic [CNT_W-1:0]   nr, nc, a5, b5, in_a5, in_b5;
  op_t                in_op;
  logic               accept, in_err, out_busy, load;
  logic [31:0]        x;
  logic               scan_last, line_last, qual, sev_div, is_row, mul_src_a;
  logic [AW-1:0]      addr_a, addr_b;
  logic               mem_we;
  logic [AW-1:0]      mem_addr;
  logic [31:0]        mem_wdata, mul_in;
  logic               div_start;
  rem_sts_t           rem_sts;

  function automatic logic [AW-1:0] addr_of(input logic [CNT_W-1:0] r,
                                            input logic [CNT_W-1:0] c);
    return AW'(int'(r) * MAX_COLS + int'(c));
  endfunction

  imeo_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (x)
  );

  imeo_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag(x)),
    .divisor  (mag(piv_r)),
    .sts      (rem_sts)
  );

  // Effective counts: zero acts as one, large values clamp to the array size.
  always_comb begin
    if (row_cnt_r == '0) begin
      nr = CNT_W'(1);
    end else if (int'(row_cnt_r) > MAX_ROWS) begin
      nr = CNT_W'(MAX_ROWS);
    end else begin
      nr = row_cnt_r;
    end
    if (col_cnt_r == '0) begin
      nc = CNT_W'(1);
    end else if (int'(col_cnt_r) > MAX_COLS) begin
      nc = CNT_W'(MAX_COLS);
    end else begin
      nc = col_cnt_r;
    end
  end

  // Input decode and index checks.
  assign in_op  = op_t'(in_data.operation);
  assign in_a5  = {1'b0, in_data.first_index};
  assign in_b5  = {1'b0, in_data.second_index};
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    case (in_op)
      OP_WRITE, OP_READ:          in_err = (in_a5 >= nr) || (in_b5 >= nc);
      OP_SWAP_ROW, OP_ADD_ROW:    in_err = (in_a5 >= nr) || (in_b5 >= nr);
      OP_SWAP_COL, OP_ADD_COL:    in_err = (in_a5 >= nc) || (in_b5 >= nc);
      OP_SCALE_ROW:               in_err = (in_a5 >= nr);
      OP_SCALE_COL:               in_err = (in_a5 >= nc);
      OP_MIN_SEARCH, OP_ROW_CHECK,
      OP_COL_CHECK, OP_SUB_CHECK: in_err = (in_a5 >= nr) || (in_a5 >= nc);
      default:                    in_err = 1'b0;
    endcase
  end

  // Shared conditions for the line walk and the scans.
  assign a5        = {1'b0, a_r};
  assign b5        = {1'b0, b_r};
  assign is_row    = (op_r == OP_SWAP_ROW) || (op_r == OP_SCALE_ROW) || (op_r == OP_ADD_ROW);
  assign mul_src_a = (op_r == OP_SCALE_ROW) || (op_r == OP_SCALE_COL);
  assign mul_in    = mul_src_a ? xa_r : xb_r;
  assign addr_a    = is_row ? addr_of(a5, n_r) : addr_of(n_r, a5);
  assign addr_b    = is_row ? addr_of(b5, n_r) : addr_of(n_r, b5);
  assign line_last = (n_r == lim_r - 1'b1);
  assign scan_last = (c_r == nc - 1'b1) && (r_r == nr - 1'b1);
  assign out_busy  = out_valid_r && out_stall;
  assign load      = (state_r == S_DONE) && !out_busy;

  always_comb begin
    case (op_r)
      OP_ROW_CHECK: qual = (r_r == a5);
      OP_COL_CHECK: qual = (c_r == a5);
      OP_SUB_CHECK: qual = (r_r > a5) && (c_r > a5);
      default:      qual = 1'b0;
    endcase
  end
  assign sev_div = qual && (x != '0) && (piv_r != '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_err) begin
            state_nxt = S_DONE;
          end else begin
            case (in_op)
              OP_READ:                   state_nxt = S_ACC;
              OP_SWAP_ROW, OP_SWAP_COL,
              OP_SCALE_ROW, OP_SCALE_COL,
              OP_ADD_ROW, OP_ADD_COL:    state_nxt = S_LRA;
              OP_MIN_SEARCH, OP_ROW_CHECK,
              OP_COL_CHECK, OP_SUB_CHECK: state_nxt = S_PIV;
              OP_COUNTS:                 state_nxt = S_ZRD;
              default:                   state_nxt = S_DONE;
            endcase
          end
        end
      end
      S_ACC:  state_nxt = S_DONE;
      S_LRA:  state_nxt = S_LRB;
      S_LRB:  state_nxt = S_LCAP;
      S_LCAP: state_nxt = S_LMUL;
      S_LMUL: state_nxt = S_LWA;
      S_LWA: begin
        if (op_r == OP_SWAP_ROW || op_r == OP_SWAP_COL) begin
          state_nxt = S_LWB;
        end else begin
          state_nxt = line_last ? S_DONE : S_LRA;
        end
      end
      S_LWB:  state_nxt = line_last ? S_DONE : S_LRA;
      S_PIV:  state_nxt = S_PIVW;
      S_PIVW: state_nxt = S_SRD;
      S_SRD:  state_nxt = S_SEV;
      S_SEV: begin
        if (sev_div) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = scan_last ? S_DONE : S_SRD;
        end
      end
      S_DIV:  if (rem_sts.done) state_nxt = scan_last ? S_DONE : S_SRD;
      S_ZRD:  state_nxt = S_ZEV;
      S_ZEV: begin
        if (x != '0) begin
          state_nxt = S_TRD;
        end else begin
          state_nxt = (c_r == nc - 1'b1) ? S_DONE : S_ZRD;
        end
      end
      S_TRD:  state_nxt = (r_r >= nr) ? S_DONE : S_TEV;
      S_TEV: begin
        if (!x[31] && (x > 32'd1)) begin
          state_nxt = (c_r == nc - 1'b1) ? S_DONE : S_TRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: if (!out_busy) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory port and remainder unit control.
  always_comb begin
    clr_nxt   = clr_r;
    op_nxt    = op_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    n_nxt     = n_r;
    lim_nxt   = lim_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    xa_nxt    = xa_r;
    xb_nxt    = xb_r;
    prod_nxt  = prod_r;
    piv_nxt   = piv_r;
    best_nxt  = best_r;
    rv_nxt    = rv_r;
    fnd_nxt   = fnd_r;
    fr_nxt    = fr_r;
    fc_nxt    = fc_r;
    zc_nxt    = zc_r;
    tc_nxt    = tc_r;
    err_nxt   = err_r;
    mem_we    = 1'b0;
    mem_addr  = addr_of(r_r, c_r);
    mem_wdata = '0;
    div_start = 1'b0;
    case (state_r)
      S_CLR: begin
        mem_we   = 1'b1;
        mem_addr = clr_r;
        clr_nxt  = clr_r + 1'b1;
      end
      S_IDLE: begin
        mem_addr = addr_of(in_a5, in_b5);
        if (accept) begin
          op_nxt   = in_op;
          a_nxt    = in_data.first_index;
          b_nxt    = in_data.second_index;
          k_nxt    = in_data.coeff;
          n_nxt    = '0;
          lim_nxt  = (in_op == OP_SWAP_ROW || in_op == OP_SCALE_ROW ||
                      in_op == OP_ADD_ROW) ? nc : nr;
          r_nxt    = '0;
          c_nxt    = '0;
          best_nxt = '0;
          rv_nxt   = '0;
          fnd_nxt  = 1'b0;
          fr_nxt   = '0;
          fc_nxt   = '0;
          zc_nxt   = '0;
          tc_nxt   = '0;
          err_nxt  = in_err;
          if (!in_err && in_op == OP_WRITE) begin
            mem_we    = 1'b1;
            mem_wdata = in_data.write_value;
          end
        end
      end
      S_ACC: rv_nxt = x;
      S_LRA: mem_addr = addr_a;
      S_LRB: begin
        mem_addr = addr_b;
        xa_nxt   = x;
      end
      S_LCAP: xb_nxt = x;
      S_LMUL: prod_nxt = mul_in * k_r;
      S_LWA: begin
        mem_addr = addr_a;
        mem_we   = 1'b1;
        if (op_r == OP_SWAP_ROW || op_r == OP_SWAP_COL) begin
          mem_wdata = xb_r;
        end else begin
          mem_wdata = mul_src_a ? prod_r : (xa_r + prod_r);
          n_nxt     = n_r + 1'b1;
        end
      end
      S_LWB: begin
        mem_addr  = addr_b;
        mem_we    = 1'b1;
        mem_wdata = xa_r;
        n_nxt     = n_r + 1'b1;
      end
      S_PIV: mem_addr = addr_of(a5, a5);
      S_PIVW: begin
        piv_nxt = x;
        r_nxt   = a5;
        c_nxt   = a5;
      end
      S_SEV: begin
        xa_nxt = x;
        if (op_r == OP_MIN_SEARCH) begin
          if (x != '0 && (!fnd_r || mag(x) < best_r)) begin
            fnd_nxt  = 1'b1;
            fr_nxt   = r_r[3:0];
            fc_nxt   = c_r[3:0];
            rv_nxt   = x;
            best_nxt = mag(x);
          end
        end else if (qual && x != '0 && piv_r == '0) begin
          fnd_nxt = 1'b1;
          fr_nxt  = r_r[3:0];
          fc_nxt  = c_r[3:0];
          rv_nxt  = x;
        end
        div_start = sev_div;
        if (!sev_div) begin
          if (c_r == nc - 1'b1) begin
            c_nxt = a5;
            r_nxt = r_r + 1'b1;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end
      S_DIV: begin
        if (rem_sts.done) begin
          if (rem_sts.nz) begin
            fnd_nxt = 1'b1;
            fr_nxt  = r_r[3:0];
            fc_nxt  = c_r[3:0];
            rv_nxt  = xa_r;
          end
          if (c_r == nc - 1'b1) begin
            c_nxt = a5;
            r_nxt = r_r + 1'b1;
          end else begin
            c_nxt = c_r + 1'b1;
          end
        end
      end
      S_ZRD: mem_addr = addr_of('0, c_r);
      S_ZEV: begin
        if (x == '0) begin
          zc_nxt = zc_r + 1'b1;
          c_nxt  = c_r + 1'b1;
        end
      end
      S_TRD: mem_addr = addr_of(r_r, c_r);
      S_TEV: begin
        if (!x[31] && (x > 32'd1)) begin
          tc_nxt = tc_r + 1'b1;
          c_nxt  = c_r + 1'b1;
          r_nxt  = r_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      row_cnt_r   <= CNT_W'(16);
      col_cnt_r   <= CNT_W'(16);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= load || out_busy;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ROW_COUNT) begin
          row_cnt_r <= cfg_data;
        end else if (cfg_index == CFG_COL_COUNT) begin
          col_cnt_r <= cfg_data;
        end
      end
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    k_r    <= k_nxt;
    n_r    <= n_nxt;
    lim_r  <= lim_nxt;
    r_r    <= r_nxt;
    c_r    <= c_nxt;
    xa_r   <= xa_nxt;
    xb_r   <= xb_nxt;
    prod_r <= prod_nxt;
    piv_r  <= piv_nxt;
    best_r <= best_nxt;
    rv_r   <= rv_nxt;
    fnd_r  <= fnd_nxt;
    fr_r   <= fr_nxt;
    fc_r   <= fc_nxt;
    zc_r   <= zc_nxt;
    tc_r   <= tc_nxt;
    err_r  <= err_nxt;
    if (load) begin
      out_data_r.read_value    <= rv_r;
      out_data_r.found         <= fnd_r;
      out_data_r.found_row     <= fr_r;
      out_data_r.found_col     <= fc_r;
      out_data_r.zero_columns  <= zc_r;
      out_data_r.torsion_count <= tc_r;
      out_data_r.index_error   <= err_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Scan position stays inside the active window while an element is evaluated.
  `IMEO_ASSERT_IMP(a_scan_range, state_r == S_SEV, (r_r < nr) && (c_r < nc))
  // The remainder unit only runs while the sequencer waits on it.
  `IMEO_ASSERT_IMP(a_rem_owner, rem_sts.busy, state_r == S_DIV)
  // An accepted beat always starts work or a result.
  `IMEO_ASSERT_NXT(a_accept_moves, accept, state_r != S_IDLE)
  // A failed index check never reports a found element.
  `IMEO_ASSERT_IMP(a_err_clean, out_valid_r && out_data_r.index_error, !out_data_r.found)

endmodule
`default_nettype wire

### tb/tb_integer_matrix_elementary_op_engine.sv
`timescale 1ns / 1ps
module tb_integer_matrix_elementary_op_engine;
  import imeo_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int LONG_HOLD = 400;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_beat_t in_data;
  logic out_valid;
  logic out_stall;
  out_beat_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0] cfg_data;

  integer_matrix_elementary_op_engine DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the matrix and the two count registers.
  logic [31:0] matrix_shadow [16][16];
  logic [4:0] rows_cfg;
  logic [4:0] cols_cfg;

  in_beat_t pending_items[$];
  out_beat_t expected_results[$];
  int mismatches;
  int idle_pct;
  int stall_pct;
  int hold_requests;
  int holds_done;
  int hold_cnt;
  int send_gap;
  int stall_gap;
  int quiet_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int eff_count(logic [4:0] v);
    if (v == 5'd0) return 1;
    return (v > 5'd16) ? 16 : int'(v);
  endfunction

  function automatic logic [31:0] abs_word(logic [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic fails_pivot(logic [31:0] x, logic [31:0] piv);
    if (x == 32'd0) return 1'b0;
    if (piv == 32'd0) return 1'b1;
    return (abs_word(x) % abs_word(piv)) != 32'd0;
  endfunction

  // Applies one operation to the shadow matrix and returns the result it gives.
  function automatic out_beat_t apply_matrix_op(in_beat_t it);
    out_beat_t res;
    int nr;
    int nc;
    int a;
    int b;
    int n;
    int r;
    int c;
    int zc;
    logic [31:0] t;
    logic [31:0] k;
    logic [31:0] x;
    logic [31:0] piv;
    logic [31:0] best;
    logic hit;
    res = '0;
    nr = eff_count(rows_cfg);
    nc = eff_count(cols_cfg);
    a = it.first_index;
    b = it.second_index;
    k = it.coeff;
    case (it.operation)
      OP_WRITE, OP_READ: begin
        if (a >= nr || b >= nc) res.index_error = 1'b1;
        else if (it.operation == OP_WRITE) matrix_shadow[a][b] = it.write_value;
        else res.read_value = matrix_shadow[a][b];
      end
      OP_SWAP_ROW: begin
        if (a >= nr || b >= nr) res.index_error = 1'b1;
        else for (n = 0; n < nc; n++) begin
          t = matrix_shadow[a][n];
          matrix_shadow[a][n] = matrix_shadow[b][n];
          matrix_shadow[b][n] = t;
        end
      end
      OP_SWAP_COL: begin
        if (a >= nc || b >= nc) res.index_error = 1'b1;
        else for (n = 0; n < nr; n++) begin
          t = matrix_shadow[n][a];
          matrix_shadow[n][a] = matrix_shadow[n][b];
          matrix_shadow[n][b] = t;
        end
      end
      OP_SCALE_ROW: begin
        if (a >= nr) res.index_error = 1'b1;
        else for (n = 0; n < nc; n++) matrix_shadow[a][n] = matrix_shadow[a][n] * k;
      end
      OP_SCALE_COL: begin
        if (a >= nc) res.index_error = 1'b1;
        else for (n = 0; n < nr; n++) matrix_shadow[n][a] = matrix_shadow[n][a] * k;
      end
      OP_ADD_ROW: begin
        if (a >= nr || b >= nr) res.index_error = 1'b1;
        else for (n = 0; n < nc; n++)
          matrix_shadow[a][n] = matrix_shadow[a][n] + k * matrix_shadow[b][n];
      end
      OP_ADD_COL: begin
        if (a >= nc || b >= nc) res.index_error = 1'b1;
        else for (n = 0; n < nr; n++)
          matrix_shadow[n][a] = matrix_shadow[n][a] + k * matrix_shadow[n][b];
      end
      OP_MIN_SEARCH, OP_ROW_CHECK, OP_COL_CHECK, OP_SUB_CHECK: begin
        if (a >= nr || a >= nc) res.index_error = 1'b1;
        else begin
          piv = matrix_shadow[a][a];
          best = '0;
          for (r = a; r < nr; r++) begin
            for (c = a; c < nc; c++) begin
              x = matrix_shadow[r][c];
              if (it.operation == OP_MIN_SEARCH) begin
                hit = (x != 32'd0) && (!res.found || abs_word(x) < best);
                if (hit) best = abs_word(x);
              end else if (it.operation == OP_ROW_CHECK) begin
                hit = (r == a) && fails_pivot(x, piv);
              end else if (it.operation == OP_COL_CHECK) begin
                hit = (c == a) && fails_pivot(x, piv);
              end else begin
                hit = (r > a) && (c > a) && fails_pivot(x, piv);
              end
              if (hit) begin
                res.found = 1'b1;
                res.found_row = r[3:0];
                res.found_col = c[3:0];
                res.read_value = x;
              end
            end
          end
        end
      end
      OP_COUNTS: begin
        zc = 0;
        while (zc < nc && matrix_shadow[0][zc] == 32'd0) zc++;
        res.zero_columns = zc[4:0];
        for (c = zc; c < nc; c++) begin
          if (c - zc >= nr) break;
          x = matrix_shadow[c - zc][c];
          if (!x[31] && x > 32'd1) res.torsion_count = res.torsion_count + 5'd1;
          else break;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch in %s: got 0x%08h, expected 0x%08h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic queue_item(logic [3:0] op, int a, int b, logic [31:0] k, logic [31:0] v);
    in_beat_t it;
    it.operation = op;
    it.first_index = a[3:0];
    it.second_index = b[3:0];
    it.coeff = k;
    it.write_value = v;
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return 32'($signed($urandom_range(0, 24)) - 12);
    if (sel < 15) return $urandom;
    if (sel == 15) return 32'h8000_0000;
    if (sel == 16) return 32'h7fff_ffff;
    if (sel == 17) return 32'hffff_ffff;
    return 32'd0;
  endfunction

  function automatic logic [31:0] pick_coeff();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 15) return 32'($signed($urandom_range(0, 6)) - 3);
    if (sel < 18) return $urandom;
    return (sel == 18) ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  // One random operation, mostly with indexes inside the active area.
  task automatic queue_random_item();
    int nr;
    int nc;
    int sel;
    int lim_a;
    int lim_b;
    int a;
    int b;
    logic [3:0] op;
    nr = eff_count(rows_cfg);
    nc = eff_count(cols_cfg);
    sel = $urandom_range(0, 99);
    if (sel < 30) op = OP_WRITE;
    else if (sel < 36) op = OP_READ;
    else if (sel < 40) op = OP_SWAP_ROW;
    else if (sel < 44) op = OP_SWAP_COL;
    else if (sel < 48) op = OP_SCALE_ROW;
    else if (sel < 52) op = OP_SCALE_COL;
    else if (sel < 60) op = OP_ADD_ROW;
    else if (sel < 68) op = OP_ADD_COL;
    else if (sel < 76) op = OP_MIN_SEARCH;
    else if (sel < 82) op = OP_ROW_CHECK;
    else if (sel < 88) op = OP_COL_CHECK;
    else if (sel < 94) op = OP_SUB_CHECK;
    else if (sel < 98) op = OP_COUNTS;
    else op = 4'($urandom_range(13, 15));
    case (op)
      OP_SWAP_COL, OP_SCALE_COL, OP_ADD_COL: lim_a = nc;
      OP_MIN_SEARCH, OP_ROW_CHECK, OP_COL_CHECK, OP_SUB_CHECK:
        lim_a = (nr < nc) ? nr : nc;
      default: lim_a = nr;
    endcase
    case (op)
      OP_WRITE, OP_READ, OP_SWAP_COL, OP_ADD_COL: lim_b = nc;
      OP_SWAP_ROW, OP_ADD_ROW: lim_b = nr;
      default: lim_b = 16;
    endcase
    a = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 15) : $urandom_range(0, lim_a - 1);
    b = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 15) : $urandom_range(0, lim_b - 1);
    queue_item(op, a, b, pick_coeff(), pick_value());
  endtask

  task automatic wait_until_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [4:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ROW_COUNT) rows_cfg = val;
    else rows_cfg = rows_cfg;
    if (idx == CFG_COL_COUNT) cols_cfg = val;
  endtask

  task automatic run_phase(logic [4:0] r, logic [4:0] c, int count);
    wait_until_drained();
    write_register(CFG_ROW_COUNT, r);
    write_register(CFG_COL_COUNT, c);
    repeat (count) queue_random_item();
  endtask

  // Input driver: offers queued items, with random idle bursts between beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(apply_matrix_op(in_data));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < idle_pct) begin
          send_gap <= $urandom_range(0, 12);
          in_valid <= 1'b0;
        end else begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Result monitor: drives the stall and checks every accepted beat.
  always @(posedge clk) begin
    out_beat_t want;
    if (out_valid && !out_stall && rst_n) begin
      if (expected_results.size() == 0) begin
        $display("%0t result beat with no expectation waiting", $realtime);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.read_value != want.read_value)
          report_mismatch("read_value", out_data.read_value, want.read_value);
        if (out_data.found != want.found)
          report_mismatch("found", 32'(out_data.found), 32'(want.found));
        if (out_data.found_row != want.found_row)
          report_mismatch("found_row", 32'(out_data.found_row), 32'(want.found_row));
        if (out_data.found_col != want.found_col)
          report_mismatch("found_col", 32'(out_data.found_col), 32'(want.found_col));
        if (out_data.zero_columns != want.zero_columns)
          report_mismatch("zero_columns", 32'(out_data.zero_columns),
                          32'(want.zero_columns));
        if (out_data.torsion_count != want.torsion_count)
          report_mismatch("torsion_count", 32'(out_data.torsion_count),
                          32'(want.torsion_count));
        if (out_data.index_error != want.index_error)
          report_mismatch("index_error", 32'(out_data.index_error),
                          32'(want.index_error));
      end
    end
    if (holds_done != hold_requests) begin
      holds_done <= hold_requests;
      hold_cnt <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap <= stall_gap - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      stall_gap <= $urandom_range(0, 12);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: ends the run after a long stretch with no beat on any channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** integer_matrix_elementary_op_engine: FAILED **");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 16; j++) matrix_shadow[i][j] = '0;
    rows_cfg = 5'd16;
    cols_cfg = 5'd16;
    mismatches = 0;
    idle_pct = 15;
    stall_pct = 15;
    hold_requests = 0;
    holds_done = 0;
    hold_cnt = 0;
    send_gap = 0;
    stall_gap = 0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ROW_COUNT;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset size: extremes, every operation, special cases.
    queue_item(OP_WRITE, 0, 0, 0, 32'h8000_0000);
    queue_item(OP_WRITE, 1, 1, 0, 32'hffff_ffff);
    queue_item(OP_WRITE, 15, 15, 0, 32'h7fff_ffff);
    queue_item(OP_READ, 15, 15, 0, 0);
    queue_item(OP_READ, 0, 0, 0, 0);
    queue_item(OP_MIN_SEARCH, 0, 0, 0, 0);
    queue_item(OP_ROW_CHECK, 0, 0, 0, 0);
    queue_item(OP_WRITE, 1, 0, 0, 32'd6);
    queue_item(OP_COL_CHECK, 0, 0, 0, 0);
    queue_item(OP_COL_CHECK, 1, 0, 0, 0);
    queue_item(OP_SUB_CHECK, 0, 0, 0, 0);
    queue_item(OP_WRITE, 2, 2, 0, 32'd3);
    queue_item(OP_COUNTS, 15, 15, 0, 0);
    queue_item(OP_SUB_CHECK, 3, 0, 0, 0);
    queue_item(OP_SWAP_ROW, 0, 15, 0, 0);
    queue_item(OP_SWAP_COL, 0, 15, 0, 0);
    queue_item(OP_SCALE_ROW, 1, 0, 32'hffff_ffff, 0);
    queue_item(OP_SCALE_COL, 15, 0, 32'h8000_0000, 0);
    queue_item(OP_ADD_ROW, 2, 2, 32'd5, 0);
    queue_item(OP_ADD_COL, 1, 15, 32'hffff_fffd, 0);
    queue_item(4'd13, 5, 10, 32'hffff_ffff, 32'hffff_ffff);
    queue_item(4'd15, 15, 15, 32'h5555_aaaa, 32'haaaa_5555);
    queue_item(OP_MIN_SEARCH, 15, 0, 0, 0);
    queue_item(OP_COUNTS, 0, 0, 0, 0);
    repeat (60) queue_random_item();

    // Count settings, the out-of-range register values among them.
    run_phase(5'd0, 5'd31, 150);
    run_phase(5'd1, 5'd1, 150);
    wait_until_drained();
    write_register(CFG_ROW_COUNT, 5'd4);
    write_register(CFG_COL_COUNT, 5'd5);
    // Long receiver hold while the sender keeps offering.
    idle_pct = 0;
    hold_requests++;
    repeat (300) queue_random_item();
    run_phase(5'd17, 5'd3, 300);
    idle_pct = 20;
    stall_pct = 0;
    run_phase(5'd5, 5'd4, 300);
    stall_pct = 25;
    run_phase(5'd31, 5'd0, 150);
    idle_pct = 10;
    run_phase(5'd3, 5'd3, 300);
    run_phase(5'd16, 5'd16, 80);
    // Final stretch with no idling on either side.
    wait_until_drained();
    idle_pct = 0;
    stall_pct = 0;
    run_phase(5'd6, 5'd6, 150);

    while (pending_items.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** integer_matrix_elementary_op_engine: PASSED **");
    end else begin
      $display("** integer_matrix_elementary_op_engine: FAILED **");
    end
    $finish;
  end

endmodule
